// ===== hw/rtl/tpmrd_pkg.sv =====
// types, constants and helper functions for the touch point filter
// no dependencies; used by every other file of the block but tpmrd_chan_if
package tpmrd_pkg;

  localparam int COORD_W           = 16;
  localparam int DEADZONE_W        = 8;
  localparam int CFG_DATA_W        = 16;
  localparam int REG_IDX_W         = 3;
  localparam int NUM_INPUT_SAMPLES = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [DEADZONE_W-1:0] deadzone_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PANEL_WIDTH  = 3'd0,
    REG_PANEL_HEIGHT = 3'd1,
    REG_ROTATION     = 3'd2,
    REG_SWAP_AXES    = 3'd3,
    REG_INVERT_X     = 3'd4,
    REG_INVERT_Y     = 3'd5,
    REG_DEADZONE     = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  localparam int        RESET_PANEL_WIDTH  = 240;
  localparam int        RESET_PANEL_HEIGHT = 240;
  localparam coord_t    RESET_WM1          = coord_t'(RESET_PANEL_WIDTH - 1);
  localparam coord_t    RESET_HM1          = coord_t'(RESET_PANEL_HEIGHT - 1);
  localparam deadzone_t RESET_DEADZONE     = deadzone_t'(4);

  // one poll burst
  typedef struct packed {
    logic   hit_a;
    coord_t raw_x_a;
    coord_t raw_y_a;
    logic   hit_b;
    coord_t raw_x_b;
    coord_t raw_y_b;
    logic   hit_c;
    coord_t raw_x_c;
    coord_t raw_y_c;
  } burst_t;

  // one filtered result
  typedef struct packed {
    logic   pressed;
    coord_t point_x;
    coord_t point_y;
  } point_t;

  // configuration write
  typedef struct packed {
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  // live configuration, panel sizes kept as size minus one
  typedef struct packed {
    coord_t    wm1;
    coord_t    hm1;
    rot_t      rotation;
    logic      swap_axes;
    logic      invert_x;
    logic      invert_y;
    deadzone_t deadzone;
  } cfg_t;

  // classified burst held between front and back
  typedef struct packed {
    logic   pressed;
    coord_t med_x;
    coord_t med_y;
  } median_t;

  typedef struct packed {
    logic    push;
    median_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic coord_t max2(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t min2(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t median3(input coord_t a, input coord_t b, input coord_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

// ===== hw/rtl/tpmrd_chan_if.sv =====
// valid/ready channel carrying one payload per transaction
// payload type comes from tpmrd_pkg at the point of instantiation
interface tpmrd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tpmrd_front.sv =====
// front end: takes bursts, picks survivors and the per-axis median
// depends on tpmrd_pkg and tpmrd_chan_if
module tpmrd_front #(
  parameter int SAMPLES_PER_BURST = 3
) (
  tpmrd_chan_if.sink               samples,
  input  tpmrd_pkg::queue_stat_t   stat,
  output tpmrd_pkg::queue_wr_t     wr
);

  localparam int USED = (SAMPLES_PER_BURST < tpmrd_pkg::NUM_INPUT_SAMPLES) ?
                        SAMPLES_PER_BURST : tpmrd_pkg::NUM_INPUT_SAMPLES;

  logic [tpmrd_pkg::NUM_INPUT_SAMPLES-1:0] hit;
  logic [tpmrd_pkg::NUM_INPUT_SAMPLES-1:0] mask;
  tpmrd_pkg::coord_t xs [tpmrd_pkg::NUM_INPUT_SAMPLES];
  tpmrd_pkg::coord_t ys [tpmrd_pkg::NUM_INPUT_SAMPLES];
  tpmrd_pkg::median_t entry;

  always_comb begin
    hit[0] = samples.data.hit_a;
    hit[1] = samples.data.hit_b;
    hit[2] = samples.data.hit_c;
    xs[0]  = samples.data.raw_x_a;
    xs[1]  = samples.data.raw_x_b;
    xs[2]  = samples.data.raw_x_c;
    ys[0]  = samples.data.raw_y_a;
    ys[1]  = samples.data.raw_y_b;
    ys[2]  = samples.data.raw_y_c;
    for (int i = 0; i < tpmrd_pkg::NUM_INPUT_SAMPLES; i++) begin
      // a hit at the origin is a controller glitch
      mask[i] = hit[i] && ((xs[i] != '0) || (ys[i] != '0)) && (i < USED);
    end
  end

  // two survivors give the larger value, one gives itself
  always_comb begin
    entry.pressed = 1'b1;
    case (mask)
      3'b111: begin
        entry.med_x = tpmrd_pkg::median3(xs[0], xs[1], xs[2]);
        entry.med_y = tpmrd_pkg::median3(ys[0], ys[1], ys[2]);
      end
      3'b011: begin
        entry.med_x = tpmrd_pkg::max2(xs[0], xs[1]);
        entry.med_y = tpmrd_pkg::max2(ys[0], ys[1]);
      end
      3'b101: begin
        entry.med_x = tpmrd_pkg::max2(xs[0], xs[2]);
        entry.med_y = tpmrd_pkg::max2(ys[0], ys[2]);
      end
      3'b110: begin
        entry.med_x = tpmrd_pkg::max2(xs[1], xs[2]);
        entry.med_y = tpmrd_pkg::max2(ys[1], ys[2]);
      end
      3'b001: begin
        entry.med_x = xs[0];
        entry.med_y = ys[0];
      end
      3'b010: begin
        entry.med_x = xs[1];
        entry.med_y = ys[1];
      end
      3'b100: begin
        entry.med_x = xs[2];
        entry.med_y = ys[2];
      end
      default: begin
        entry.pressed = 1'b0;
        entry.med_x   = '0;
        entry.med_y   = '0;
      end
    endcase
  end

  assign samples.ready = !stat.full;
  assign wr.push       = samples.valid && !stat.full;
  assign wr.entry      = entry;

endmodule

// ===== hw/rtl/tpmrd_queue.sv =====
// short fifo of classified bursts between front and back
// depends on tpmrd_pkg
module tpmrd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  tpmrd_pkg::queue_wr_t   wr,
  input  logic                   pop,
  output tpmrd_pkg::queue_stat_t stat,
  output tpmrd_pkg::median_t     head
);

  localparam logic [tpmrd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    tpmrd_pkg::QUEUE_PTR_W'(tpmrd_pkg::QUEUE_DEPTH - 1);
  localparam logic [tpmrd_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
    tpmrd_pkg::QUEUE_CNT_W'(tpmrd_pkg::QUEUE_DEPTH);

  tpmrd_pkg::median_t mem [tpmrd_pkg::QUEUE_DEPTH];
  logic [tpmrd_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [tpmrd_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [tpmrd_pkg::QUEUE_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

endmodule

// ===== hw/rtl/tpmrd_back.sv =====
// back end: orientation, deadzone hold, held point and result register
// depends on tpmrd_pkg and tpmrd_chan_if
module tpmrd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tpmrd_pkg::cfg_t        cfg,
  input  tpmrd_pkg::median_t     head,
  input  tpmrd_pkg::queue_stat_t stat,
  output logic                   pop,
  tpmrd_chan_if.source           point
);

  tpmrd_pkg::coord_t prev_x;
  tpmrd_pkg::coord_t prev_y;
  logic              seen_touch;

  tpmrd_pkg::coord_t rot_x, rot_y;
  tpmrd_pkg::coord_t sw_x, sw_y;
  tpmrd_pkg::coord_t fin_x, fin_y;
  tpmrd_pkg::coord_t dx, dy;
  logic              hold;
  tpmrd_pkg::point_t result;

  assign pop = !stat.empty && (!point.valid || point.ready);

  always_comb begin
    case (cfg.rotation)
      tpmrd_pkg::ROT_0: begin
        rot_x = head.med_x;
        rot_y = head.med_y;
      end
      tpmrd_pkg::ROT_90: begin
        rot_x = cfg.hm1 - head.med_y;
        rot_y = head.med_x;
      end
      tpmrd_pkg::ROT_180: begin
        rot_x = cfg.wm1 - head.med_x;
        rot_y = cfg.hm1 - head.med_y;
      end
      tpmrd_pkg::ROT_270: begin
        rot_x = head.med_y;
        rot_y = cfg.wm1 - head.med_x;
      end
      default: begin
        rot_x = head.med_x;
        rot_y = head.med_y;
      end
    endcase
    sw_x  = cfg.swap_axes ? rot_y : rot_x;
    sw_y  = cfg.swap_axes ? rot_x : rot_y;
    fin_x = cfg.invert_x ? cfg.wm1 - sw_x : sw_x;
    fin_y = cfg.invert_y ? cfg.hm1 - sw_y : sw_y;
    dx    = (fin_x > prev_x) ? fin_x - prev_x : prev_x - fin_x;
    dy    = (fin_y > prev_y) ? fin_y - prev_y : prev_y - fin_y;
    hold  = seen_touch &&
            (dx <= tpmrd_pkg::COORD_W'(cfg.deadzone)) &&
            (dy <= tpmrd_pkg::COORD_W'(cfg.deadzone));
    result.pressed = head.pressed;
    if (!head.pressed || hold) begin
      result.point_x = prev_x;
      result.point_y = prev_y;
    end else begin
      result.point_x = fin_x;
      result.point_y = fin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      point.data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      seen_touch  <= 1'b0;
    end else begin
      if (pop) begin
        point.valid <= 1'b1;
      end else if (point.ready) begin
        point.valid <= 1'b0;
      end
      if (pop && head.pressed) begin
        prev_x     <= result.point_x;
        prev_y     <= result.point_y;
        seen_touch <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // a release reports the held point unchanged
  a_release_holds: assert property (@(posedge clk) disable iff (rst)
    pop && !head.pressed |=> !point.data.pressed &&
      point.data.point_x == $past(prev_x) && point.data.point_y == $past(prev_y))
    else $error("release did not report the held point");

  // the touch mark is sticky outside reset
  a_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(seen_touch))
    else $error("touch mark cleared without reset");

  // every popped burst lands in the result register
  a_pop_lands: assert property (@(posedge clk) disable iff (rst)
    pop |=> point.valid)
    else $error("popped burst produced no result");

  // a pressed result always becomes the held point
  a_prev_tracks: assert property (@(posedge clk) disable iff (rst)
    pop && head.pressed |=> prev_x == point.data.point_x &&
      prev_y == point.data.point_y && seen_touch)
    else $error("held point does not follow the last pressed result");
`endif

endmodule

// ===== hw/rtl/touch_point_median_rotate_deadzone.sv =====
// a burst taken from the samples channel passes the queue, then the result register, before it shows as a result
// throughput: one burst per cycle while the queue is not full, set by the combinational orientation and deadzone path
// the two-entry queue keeps bursts flowing while a result waits to be taken
// reset: synchronous, clears queue, held point and touch mark, loads register defaults
// no clearing pass; the block takes bursts in the first cycle after reset
module touch_point_median_rotate_deadzone #(
  parameter int SAMPLES_PER_BURST = 3
) (
  input logic          clk,
  input logic          rst,
  tpmrd_chan_if.sink   samples,
  tpmrd_chan_if.source point,
  tpmrd_chan_if.sink   cfg
);

  // live configuration, panel sizes stored as size minus one
  tpmrd_pkg::cfg_t regs;

  tpmrd_pkg::queue_wr_t   wr;
  tpmrd_pkg::queue_stat_t stat;
  tpmrd_pkg::median_t     head;
  logic                   pop;

  // the register port never stalls
  assign cfg.ready = 1'b1;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wm1       <= tpmrd_pkg::RESET_WM1;
      regs.hm1       <= tpmrd_pkg::RESET_HM1;
      regs.rotation  <= tpmrd_pkg::ROT_0;
      regs.swap_axes <= 1'b0;
      regs.invert_x  <= 1'b0;
      regs.invert_y  <= 1'b0;
      regs.deadzone  <= tpmrd_pkg::RESET_DEADZONE;
    end else if (cfg.valid) begin
      case (cfg.data.reg_index)
        tpmrd_pkg::REG_PANEL_WIDTH: begin
          // size minus one wraps like the rest of the arithmetic
          regs.wm1 <= tpmrd_pkg::COORD_W'(cfg.data.wdata) - 1'b1;
        end
        tpmrd_pkg::REG_PANEL_HEIGHT: begin
          regs.hm1 <= tpmrd_pkg::COORD_W'(cfg.data.wdata) - 1'b1;
        end
        tpmrd_pkg::REG_ROTATION: begin
          regs.rotation <= tpmrd_pkg::rot_t'(cfg.data.wdata[1:0]);
        end
        tpmrd_pkg::REG_SWAP_AXES: begin
          regs.swap_axes <= cfg.data.wdata[0];
        end
        tpmrd_pkg::REG_INVERT_X: begin
          regs.invert_x <= cfg.data.wdata[0];
        end
        tpmrd_pkg::REG_INVERT_Y: begin
          regs.invert_y <= cfg.data.wdata[0];
        end
        tpmrd_pkg::REG_DEADZONE: begin
          regs.deadzone <= cfg.data.wdata[tpmrd_pkg::DEADZONE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: survivor mask and per-axis median, pushes into the queue
  tpmrd_front #(
    .SAMPLES_PER_BURST(SAMPLES_PER_BURST)
  ) u_front (
    .samples (samples),
    .stat    (stat),
    .wr      (wr)
  );

  // decouples the burst side from the result side
  tpmrd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .stat (stat),
    .head (head)
  );

  // back: orientation, deadzone against the held point, result register
  tpmrd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (regs),
    .head  (head),
    .stat  (stat),
    .pop   (pop),
    .point (point)
  );

endmodule
